### rtl/core/pbrd_pkg.sv
// types and constants shared by the packbits run decoder modules
package pbrd_pkg;

  // configuration register indexes
  localparam int CFG_INDEX_WIDTH = 2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SOURCE_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_OUTPUT_LIMIT  = 2'd1;

  // fixed field widths
  localparam int CFG_DATA_WIDTH = 24;
  localparam int BYTE_WIDTH     = 8;
  localparam int BW_WIDTH       = 24;
  localparam int OUT_DATA_WIDTH = 40;

  // header codes
  localparam logic [BYTE_WIDTH-1:0] NOP_HEADER = 8'h80;

  // op queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_WIDTH  = 1;

  // operation kinds passed from front to back
  typedef enum logic [1:0] {
    OP_CHECK = 2'd0,  // run header: fail if flag set or run passes output limit
    OP_NOP   = 2'd1,  // no-op header: end the job if flag set or output limit reached
    OP_DATA  = 2'd2   // literal or repeat value with its count
  } op_kind_t;

  typedef struct packed {
    op_kind_t              kind;
    logic [BYTE_WIDTH-1:0] value;
    logic [BYTE_WIDTH-1:0] count;
    logic                  flag;   // source side has ended or overrun
  } op_t;

  // job control from the configuration port
  typedef struct packed {
    logic restart;
    logic restart_done;  // new job has a zero length
  } job_ctl_t;

endpackage

### rtl/core/pbrd_front.sv
// front end: accepts compressed bytes, tracks source position and header phase
module pbrd_front
  import pbrd_pkg::*;
#(
  parameter int COUNT_WIDTH = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  job_ctl_t               ctl,
  input  logic [COUNT_WIDTH-1:0] source_length,
  input  logic                   in_valid,
  input  logic [BYTE_WIDTH-1:0]  code_byte,
  output logic                   in_ready,
  output logic                   push,
  output op_t                    push_op,
  input  logic                   queue_full
);

  localparam int SUM_WIDTH = COUNT_WIDTH + 1;

  typedef enum logic [3:0] {
    PH_HEADER  = 4'b0001,
    PH_LITERAL = 4'b0010,
    PH_REPEAT  = 4'b0100,
    PH_DONE    = 4'b1000
  } phase_t;

  phase_t                 phase, phase_next;
  logic [BYTE_WIDTH-1:0]  run_remaining, run_remaining_next;
  logic [COUNT_WIDTH-1:0] source_count, source_count_next;

  logic                   work;
  logic [COUNT_WIDTH-1:0] src_inc;
  logic                   src_end;
  logic [BYTE_WIDTH-1:0]  lit_cnt;
  logic [BYTE_WIDTH-1:0]  rep_cnt;
  logic [SUM_WIDTH-1:0]   lit_sum;
  logic                   lit_over;

  // done phase swallows bytes, otherwise wait for queue room
  assign in_ready = (phase == PH_DONE) || !queue_full;
  assign work     = in_valid && in_ready && (phase != PH_DONE);

  // header arithmetic
  assign src_inc  = source_count + 1'b1;
  assign src_end  = (src_inc >= source_length);
  assign lit_cnt  = {1'b0, code_byte[BYTE_WIDTH-2:0]} + 8'd1;
  assign rep_cnt  = BYTE_WIDTH'(9'd257 - {1'b0, code_byte});
  assign lit_sum  = {1'b0, src_inc} + SUM_WIDTH'(lit_cnt);
  assign lit_over = (lit_sum > {1'b0, source_length});

  // classify the byte and pick the next phase
  always_comb begin
    phase_next         = phase;
    run_remaining_next = run_remaining;
    source_count_next  = source_count;
    push               = 1'b0;
    push_op            = '{kind: OP_NOP, value: '0, count: '0, flag: 1'b0};
    if (work) begin
      source_count_next = src_inc;
      push              = 1'b1;
      unique case (phase)
        PH_HEADER: begin
          if (!code_byte[BYTE_WIDTH-1]) begin
            push_op = '{kind: OP_CHECK, value: '0, count: lit_cnt, flag: lit_over};
            if (lit_over) begin
              phase_next = PH_DONE;
            end else begin
              phase_next         = PH_LITERAL;
              run_remaining_next = lit_cnt;
            end
          end else if (code_byte == NOP_HEADER) begin
            push_op = '{kind: OP_NOP, value: '0, count: '0, flag: src_end};
            if (src_end) begin
              phase_next = PH_DONE;
            end
          end else begin
            push_op = '{kind: OP_CHECK, value: '0, count: rep_cnt, flag: src_end};
            if (src_end) begin
              phase_next = PH_DONE;
            end else begin
              phase_next         = PH_REPEAT;
              run_remaining_next = rep_cnt;
            end
          end
        end
        PH_LITERAL: begin
          push_op            = '{kind: OP_DATA, value: code_byte, count: 8'd1, flag: src_end};
          run_remaining_next = run_remaining - 1'b1;
          if (src_end) begin
            phase_next = PH_DONE;
          end else if (run_remaining == 8'd1) begin
            phase_next = PH_HEADER;
          end
        end
        PH_REPEAT: begin
          push_op            = '{kind: OP_DATA, value: code_byte, count: run_remaining,
                                 flag: src_end};
          run_remaining_next = '0;
          phase_next         = src_end ? PH_DONE : PH_HEADER;
        end
        PH_DONE: begin
          push = 1'b0;
        end
        default: begin
          phase_next = PH_DONE;
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_DONE;
      run_remaining <= '0;
      source_count  <= '0;
    end else if (ctl.restart) begin
      phase         <= ctl.restart_done ? PH_DONE : PH_HEADER;
      run_remaining <= '0;
      source_count  <= '0;
    end else begin
      phase         <= phase_next;
      run_remaining <= run_remaining_next;
      source_count  <= source_count_next;
    end
  end

endmodule

### rtl/core/pbrd_queue.sv
// short op queue that decouples the front end from the result stage
module pbrd_queue
  import pbrd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic flush,
  input  logic push,
  input  op_t  push_op,
  output logic full,
  input  logic pop,
  output op_t  head_op,
  output logic empty
);

  op_t                     entries [QUEUE_DEPTH];
  logic [QPTR_WIDTH-1:0]   wr_ptr;
  logic [QPTR_WIDTH-1:0]   rd_ptr;
  logic [QPTR_WIDTH:0]     fill;
  logic                    do_push;
  logic                    do_pop;

  assign full    = (fill == (QPTR_WIDTH+1)'(QUEUE_DEPTH));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head_op = entries[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst || flush) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill <= fill + (QPTR_WIDTH+1)'(do_push) - (QPTR_WIDTH+1)'(do_pop);
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_op;
    end
  end

endmodule

### rtl/core/pbrd_back.sv
// back end: applies ops against the output count and holds the result word
module pbrd_back
  import pbrd_pkg::*;
#(
  parameter int COUNT_WIDTH = 24
) (
  input  logic                      clk,
  input  logic                      rst,
  input  job_ctl_t                  ctl,
  input  logic [COUNT_WIDTH-1:0]    output_limit,
  input  op_t                       head_op,
  input  logic                      queue_empty,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [BYTE_WIDTH-1:0]     value,
  output logic [BYTE_WIDTH-1:0]     run_length,
  output logic                      last,
  output logic                      failed,
  output logic [BW_WIDTH-1:0]       bytes_written
);

  localparam int SUM_WIDTH = COUNT_WIDTH + 1;

  logic                   done;
  logic [COUNT_WIDTH-1:0] output_count, output_count_next;
  logic [SUM_WIDTH-1:0]   oc_sum;
  logic                   emit;
  logic                   emit_last;
  logic                   emit_failed;
  logic [BYTE_WIDTH-1:0]  emit_value;
  logic [BYTE_WIDTH-1:0]  emit_len;

  // take an op whenever the output word is free
  assign pop    = !queue_empty && (!out_valid || out_ready);
  assign oc_sum = {1'b0, output_count} + SUM_WIDTH'(head_op.count);

  // decide what the head op produces
  always_comb begin
    emit              = 1'b0;
    emit_last         = 1'b0;
    emit_failed       = 1'b0;
    emit_value        = '0;
    emit_len          = '0;
    output_count_next = output_count;
    if (!done) begin
      unique case (head_op.kind)
        OP_CHECK: begin
          if (head_op.flag || (oc_sum > {1'b0, output_limit})) begin
            emit        = 1'b1;
            emit_last   = 1'b1;
            emit_failed = 1'b1;
          end
        end
        OP_NOP: begin
          if (head_op.flag || (output_count >= output_limit)) begin
            emit      = 1'b1;
            emit_last = 1'b1;
          end
        end
        OP_DATA: begin
          emit              = 1'b1;
          emit_value        = head_op.value;
          emit_len          = head_op.count;
          emit_last         = head_op.flag || (oc_sum >= {1'b0, output_limit});
          output_count_next = oc_sum[COUNT_WIDTH-1:0];
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
  end

  // job state
  always_ff @(posedge clk) begin
    if (rst) begin
      done         <= 1'b1;
      output_count <= '0;
    end else if (ctl.restart) begin
      done         <= ctl.restart_done;
      output_count <= '0;
    end else if (pop) begin
      output_count <= output_count_next;
      if (emit && emit_last) begin
        done <= 1'b1;
      end
    end
  end

  // output word valid
  always_ff @(posedge clk) begin
    if (rst || ctl.restart) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output word payload
  always_ff @(posedge clk) begin
    if (pop && emit) begin
      value         <= emit_value;
      run_length    <= emit_len;
      last          <= emit_last;
      failed        <= emit_failed;
      bytes_written <= BW_WIDTH'(output_count_next);
    end
  end

endmodule

### rtl/core/packbits_run_decoder.sv
// top level of the packbits run decoder
// Decodes a PackBits stream into (value, run length) words, one compressed byte
// per cycle in steady state: the front end classifies each byte against the
// source length, a two-word op queue sits in between, and the back end checks
// the output limit and holds the result word. While a result word waits, input
// keeps flowing until the queue is full, then stalls. A result word is registered
// in the op queue and then in the output word, and waits in the queue while an
// earlier result word is not taken. Writing either register restarts the job;
// a zero length gives no words at all.
module packbits_run_decoder
  import pbrd_pkg::*;
#(
  parameter int COUNT_WIDTH = 24
) (
  input  logic                       clk,
  input  logic                       rst,
  // configuration write channel
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  // compressed byte stream
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [BYTE_WIDTH-1:0]      s_axis_tdata,   // [7:0] code_byte
  // decoded run stream
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [OUT_DATA_WIDTH-1:0]  m_axis_tdata,   // [7:0] value, [15:8] run_length,
                                                     // [39:16] bytes_written
  output logic                       m_axis_tlast,
  output logic                       m_axis_tuser    // [0] failed
);

  logic [COUNT_WIDTH-1:0] source_length, source_length_next;
  logic [COUNT_WIDTH-1:0] output_limit, output_limit_next;
  logic                   cfg_write;
  job_ctl_t               ctl;

  logic                   q_push;
  op_t                    q_push_op;
  logic                   q_full;
  logic                   q_pop;
  op_t                    q_head;
  logic                   q_empty;

  logic [BYTE_WIDTH-1:0]  out_value;
  logic [BYTE_WIDTH-1:0]  out_len;
  logic [BW_WIDTH-1:0]    out_bytes;

  // configuration registers
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready &&
                     ((cfg_index == REG_SOURCE_LENGTH) || (cfg_index == REG_OUTPUT_LIMIT));

  always_comb begin
    source_length_next = source_length;
    output_limit_next  = output_limit;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SOURCE_LENGTH: source_length_next = COUNT_WIDTH'(cfg_data);
        REG_OUTPUT_LIMIT:  output_limit_next  = COUNT_WIDTH'(cfg_data);
        default: begin
          source_length_next = source_length;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      source_length <= '0;
      output_limit  <= '0;
    end else begin
      source_length <= source_length_next;
      output_limit  <= output_limit_next;
    end
  end

  // restart both halves with the new lengths
  assign ctl.restart      = cfg_write;
  assign ctl.restart_done = (source_length_next == '0) || (output_limit_next == '0);

  pbrd_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .source_length(source_length),
    .in_valid     (s_axis_tvalid),
    .code_byte    (s_axis_tdata),
    .in_ready     (s_axis_tready),
    .push         (q_push),
    .push_op      (q_push_op),
    .queue_full   (q_full)
  );

  pbrd_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .flush  (ctl.restart),
    .push   (q_push),
    .push_op(q_push_op),
    .full   (q_full),
    .pop    (q_pop),
    .head_op(q_head),
    .empty  (q_empty)
  );

  pbrd_back #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .output_limit (output_limit),
    .head_op      (q_head),
    .queue_empty  (q_empty),
    .pop          (q_pop),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .value        (out_value),
    .run_length   (out_len),
    .last         (m_axis_tlast),
    .failed       (m_axis_tuser),
    .bytes_written(out_bytes)
  );

  // pack the result word
  assign m_axis_tdata = {out_bytes, out_len, out_value};

endmodule

### verif/packbits_run_checker.sv
// checker for the packbits run decoder: predicts run words and compares them
`timescale 1ns / 100ps

module packbits_run_checker
  import pbrd_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  input  logic                       s_axis_tvalid,
  input  logic                       s_axis_tready,
  input  logic [BYTE_WIDTH-1:0]      s_axis_tdata,
  input  logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  input  logic [OUT_DATA_WIDTH-1:0]  m_axis_tdata,
  input  logic                       m_axis_tlast,
  input  logic                       m_axis_tuser,
  output int                         mismatches,
  output int                         words_due,
  output int                         words_checked,
  output int                         overruns
);

  typedef enum logic [1:0] {
    WANT_HEADER,
    WANT_LITERAL,
    WANT_REPEAT,
    JOB_DONE
  } decode_phase_t;

  typedef struct packed {
    logic [BYTE_WIDTH-1:0] value;
    logic [BYTE_WIDTH-1:0] run_length;
    logic                  last;
    logic                  failed;
    logic [BW_WIDTH-1:0]   written;
  } run_word_t;

  // predicted decoder state
  run_word_t     runs_expected[$];
  decode_phase_t phase;
  int unsigned   src_len;
  int unsigned   out_lim;
  int unsigned   src_seen;
  int unsigned   out_made;
  int unsigned   run_left;

  // new job: counters cleared, zero length finishes at once
  task automatic restart_job();
    src_seen = 0;
    out_made = 0;
    run_left = 0;
    phase    = (src_len == 0 || out_lim == 0) ? JOB_DONE : WANT_HEADER;
  endtask

  function automatic bit job_at_end();
    return src_seen >= src_len || out_made >= out_lim;
  endfunction

  // queue one predicted word; a last word closes the job
  task automatic push_run(input logic [7:0] value, input int unsigned len,
                          input bit last, input bit failed);
    run_word_t w;
    w.value      = value;
    w.run_length = len[7:0];
    w.last       = last;
    w.failed     = failed;
    w.written    = out_made[BW_WIDTH-1:0];
    runs_expected.push_back(w);
    if (last) phase = JOB_DONE;
  endtask

  // advance the prediction by one compressed byte
  task automatic decode_byte(input logic [7:0] b);
    int unsigned count;
    if (phase == JOB_DONE) return;
    src_seen++;
    case (phase)
      WANT_HEADER: begin
        if (b < NOP_HEADER) begin
          count = b + 1;
          if (src_seen + count > src_len || out_made + count > out_lim) begin
            push_run(8'h00, 0, 1'b1, 1'b1);
          end else begin
            run_left = count;
            phase    = WANT_LITERAL;
          end
        end else if (b == NOP_HEADER) begin
          if (job_at_end()) push_run(8'h00, 0, 1'b1, 1'b0);
        end else begin
          count = 257 - b;
          if (src_seen >= src_len || out_made + count > out_lim) begin
            push_run(8'h00, 0, 1'b1, 1'b1);
          end else begin
            run_left = count;
            phase    = WANT_REPEAT;
          end
        end
      end
      WANT_LITERAL: begin
        out_made++;
        if (run_left > 0) run_left--;
        if (run_left == 0) phase = WANT_HEADER;
        push_run(b, 1, job_at_end(), 1'b0);
      end
      default: begin
        count    = run_left;
        out_made = out_made + count;
        run_left = 0;
        phase    = WANT_HEADER;
        push_run(b, count, job_at_end(), 1'b0);
      end
    endcase
  endtask

  // compare one delivered word with the oldest prediction
  task automatic check_run(input run_word_t got);
    run_word_t want;
    if (runs_expected.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t unexpected word: value %h len %0d last %b failed %b written %0d",
                 $realtime, got.value, got.run_length, got.last, got.failed, got.written);
      return;
    end
    want = runs_expected.pop_front();
    words_checked++;
    if (want.failed) overruns++;
    if (got.value !== want.value || got.run_length !== want.run_length ||
        got.last !== want.last || got.failed !== want.failed ||
        got.written !== want.written) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t word mismatch: expected value %h len %0d last %b failed %b written %0d",
                 $realtime, want.value, want.run_length, want.last, want.failed,
                 want.written);
        $display("%0t                  actual value %h len %0d last %b failed %b written %0d",
                 $realtime, got.value, got.run_length, got.last, got.failed, got.written);
      end
    end
  endtask

  // watch all three channels at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      src_len = 0;
      out_lim = 0;
      restart_job();
      runs_expected.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready)
        check_run({m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tlast, m_axis_tuser,
                   m_axis_tdata[39:16]});
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_SOURCE_LENGTH) begin
          src_len = 32'(cfg_data);
          restart_job();
        end else if (cfg_index == REG_OUTPUT_LIMIT) begin
          out_lim = 32'(cfg_data);
          restart_job();
        end
      end
      if (s_axis_tvalid && s_axis_tready) decode_byte(s_axis_tdata);
    end
    words_due <= runs_expected.size();
  end

endmodule

### verif/tb_packbits_run_decoder.sv
// testbench top for the packbits run decoder: stimulus, idling and verdict
`timescale 1ns / 100ps

module tb_packbits_run_decoder;
  import pbrd_pkg::*;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 120;
  localparam int PHASE_ITEMS   = 350;

  typedef logic [7:0] byte_q_t[$];

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data;
  logic                       s_axis_tvalid;
  logic                       s_axis_tready;
  logic [BYTE_WIDTH-1:0]      s_axis_tdata;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  logic [OUT_DATA_WIDTH-1:0]  m_axis_tdata;
  logic                       m_axis_tlast;
  logic                       m_axis_tuser;

  int mismatches;
  int words_due;
  int words_checked;
  int overruns;

  int send_gap_pct = 0;
  int stall_pct    = 0;
  int hold_asks    = 0;
  int hold_seen    = 0;
  int hold_left    = 0;
  int cycle_count  = 0;
  int jobs_run     = 0;
  int bytes_sent   = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  packbits_run_decoder DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  packbits_run_checker run_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .mismatches    (mismatches),
    .words_due     (words_due),
    .words_checked (words_checked),
    .overruns      (overruns)
  );

  // run word receiver: random stalls, or a long hold when asked
  always @(negedge clk) begin
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_asks != hold_seen) begin
      hold_seen     <= hold_asks;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout with %0d words outstanding", words_due);
      $display("simulation failed");
      $finish;
    end
  end

  // offer one compressed byte, with random idle cycles ahead of it
  task automatic put_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
    bytes_sent++;
    @(negedge clk);
  endtask

  // stop sending and wait until every predicted word has arrived
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (words_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // write both job registers back to back
  task automatic set_job(input int unsigned src, input int unsigned lim);
    cfg_valid <= 1'b1;
    cfg_index <= REG_SOURCE_LENGTH;
    cfg_data  <= src[CFG_DATA_WIDTH-1:0];
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_index <= REG_OUTPUT_LIMIT;
    cfg_data  <= lim[CFG_DATA_WIDTH-1:0];
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_job(input int unsigned src, input int unsigned lim,
                         input byte_q_t stream, input bit hold_output = 1'b0);
    wait_idle();
    set_job(src, lim);
    if (hold_output) hold_asks <= hold_asks + 1;
    foreach (stream[i]) put_byte(stream[i]);
    jobs_run++;
  endtask

  // append one packet: literal, repeat or no-op, mostly short
  function automatic void add_packet(ref byte_q_t stream, ref int unsigned produced);
    int          pick;
    int unsigned n;
    pick = $urandom_range(99);
    if (pick < 45) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(128, 1) : $urandom_range(8, 1);
      stream.push_back(8'(n - 1));
      repeat (n) stream.push_back(8'($urandom_range(255)));
      produced += n;
    end else if (pick < 90) begin
      n = ($urandom_range(3) == 0) ? $urandom_range(128, 2) : $urandom_range(12, 2);
      stream.push_back(8'(257 - n));
      stream.push_back(8'($urandom_range(255)));
      produced += n;
    end else begin
      stream.push_back(NOP_HEADER);
    end
  endfunction

  // one random job: well-formed, cut by either length, noise, or empty
  task automatic random_job();
    byte_q_t     stream;
    int unsigned produced;
    int unsigned src;
    int unsigned lim;
    int          pick;
    produced = 0;
    repeat (($urandom_range(7) == 0) ? $urandom_range(24, 8) : $urandom_range(6, 1))
      add_packet(stream, produced);
    src  = stream.size();
    lim  = produced + $urandom_range(200);
    pick = $urandom_range(99);
    if (pick < 50) begin
      if ($urandom_range(1)) lim = produced;
      if ($urandom_range(9) == 0) lim = 24'hFFFFFF;
      if (lim == 0) lim = 1;
    end else if (pick < 70) begin
      lim = (produced > 1) ? $urandom_range(produced - 1, 1) : 1;
    end else if (pick < 88) begin
      src = $urandom_range(stream.size(), 1);
      while (stream.size() > src) void'(stream.pop_back());
      if ($urandom_range(3) == 0) lim = 24'hFFFFFF;
    end else if (pick < 95) begin
      stream.delete();
      repeat ($urandom_range(20, 1)) stream.push_back(8'($urandom_range(255)));
      src = stream.size();
      lim = $urandom_range(400, 1);
    end else begin
      if ($urandom_range(1)) src = 0;
      else lim = 0;
      while (stream.size() > 4) void'(stream.pop_back());
    end
    // a few bytes past the end of the job are ignored
    if ($urandom_range(3) == 0)
      repeat ($urandom_range(3, 1)) stream.push_back(8'($urandom_range(255)));
    run_job(src, lim, stream);
  endtask

  // long literal job with the receiver held off so the input backs up
  task automatic hold_off_job();
    byte_q_t stream;
    repeat (4) begin
      stream.push_back(8'd15);
      repeat (16) stream.push_back(8'($urandom_range(255)));
    end
    run_job(stream.size(), 64, stream, 1'b1);
  endtask

  initial begin
    rst           = 1'b1;
    cfg_valid     = 1'b0;
    cfg_index     = REG_SOURCE_LENGTH;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: both lengths zero after reset, nothing comes out
    put_byte(8'h05);
    // zero source length, then zero output limit
    run_job(0, 10, '{8'h00});
    run_job(5, 0, '{8'h00, 8'h33});
    // no-op header, then a one-byte literal that ends the source
    run_job(3, 24'hFFFFFF, '{8'h80, 8'h00, 8'hFF});
    // no-op header as the final source byte
    run_job(1, 5, '{8'h80});
    // longest repeat hits both lengths at once, trailing byte ignored
    run_job(2, 128, '{8'h81, 8'hAA, 8'h55});
    // repeat passing the output limit
    run_job(4, 1, '{8'hFF});
    // repeat header with no value byte left in the source
    run_job(1, 9, '{8'hFE});
    // literal passing the source length, then passing the output limit
    run_job(2, 9, '{8'h01});
    run_job(9, 1, '{8'h01});
    // output limit reached exactly at the end of a literal
    run_job(9, 2, '{8'h01, 8'h11, 8'h22, 8'h7F});
    // largest lengths, job left open and restarted by the next write
    run_job(24'hFFFFFF, 24'hFFFFFF, '{8'hFD, 8'h00, 8'h7F});

    // random jobs under four idle and stall mixes
    for (int mix = 0; mix < 4; mix++) begin
      send_gap_pct = (mix == 1) ? 62 : (mix == 3) ? 31 : 0;
      stall_pct   <= (mix == 2) ? 62 : (mix == 3) ? 31 : 0;
      if (mix == 0) hold_off_job();
      while (bytes_sent < PHASE_ITEMS * (mix + 1)) random_job();
    end

    wait_idle();
    $display("ran %0d jobs over %0d compressed bytes; checked %0d run words (%0d overruns)",
             jobs_run, bytes_sent, words_checked, overruns);
    $display("idle mixes: none, sender gaps, receiver stalls, both; one long output hold");
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
